FILE: hw/rtl/matrix_4x4_row_transform_core_macros.svh
// Assertion macros for the 4x4 matrix row transform core.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MATRIX_4X4_ROW_TRANSFORM_CORE_MACROS_SVH
`define MATRIX_4X4_ROW_TRANSFORM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define M4RT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("m4rt: same-cycle check failed");
`define M4RT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("m4rt: next-cycle check failed");
`else
`define M4RT_ASSERT_NOW(label, ante, cons)
`define M4RT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/m4rt_pkg.sv
// Shared types and constants for the 4x4 matrix row transform core.
// No dependencies.
`timescale 1ns / 1ps
package m4rt_pkg;
	localparam int DIM     = 4;
	localparam int ROW_W   = 2;
	localparam int WORD_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 2 * WORD_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int SHIFT_W = ACC_W - FRAC_W;

	localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MUL  = 1'b1
	} m4rt_cmd_t;

	typedef struct packed {
		m4rt_cmd_t                     cmd;
		logic [ROW_W-1:0]              row;
		logic [DIM-1:0][WORD_W-1:0]    elem;
		logic [DIM-1:0][ACC_W-1:0]     acc;
	} m4rt_item_t;
endpackage

FILE: hw/rtl/m4rt_if.sv
// Request and result channel interfaces for the 4x4 matrix row transform core.
// Depends on m4rt_pkg.
`timescale 1ns / 1ps
interface m4rt_req_if import m4rt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [ROW_W-1:0]         row_index;
	logic signed [WORD_W-1:0] elem0;
	logic signed [WORD_W-1:0] elem1;
	logic signed [WORD_W-1:0] elem2;
	logic signed [WORD_W-1:0] elem3;

	modport source (output valid, command, row_index, elem0, elem1, elem2, elem3,
		input ready);
	modport sink (input valid, command, row_index, elem0, elem1, elem2, elem3,
		output ready);
endinterface

interface m4rt_res_if import m4rt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ROW_W-1:0]         out_row;
	logic signed [WORD_W-1:0] out_col0;
	logic signed [WORD_W-1:0] out_col1;
	logic signed [WORD_W-1:0] out_col2;
	logic signed [WORD_W-1:0] out_col3;
	logic                     saturated;

	modport source (output valid, out_row, out_col0, out_col1, out_col2, out_col3,
		saturated, input ready);
	modport sink (input valid, out_row, out_col0, out_col1, out_col2, out_col3,
		saturated, output ready);
endinterface

FILE: hw/rtl/m4rt_cell.sv
// One cell of the row transform chain: holds one row of the stored matrix,
// multiplies its left element against it and adds into the running sums.
// Depends on m4rt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "matrix_4x4_row_transform_core_macros.svh"
module m4rt_cell
	import m4rt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] cell_idx,
	input  logic             up_valid,
	input  m4rt_item_t       up_item,
	output logic             up_ready,
	output logic             dn_valid,
	output m4rt_item_t       dn_item,
	input  logic             dn_ready
);
	logic [DIM-1:0][WORD_W-1:0] coef_q;
	logic                       v_s1;
	logic                       v_s2;
	m4rt_item_t                 item_s1;
	m4rt_item_t                 item_s2;
	logic signed [PROD_W-1:0]   prod_s1 [DIM];
	logic                       rdy_s1;
	logic                       rdy_s2;
	logic                       wr_en;
	logic signed [WORD_W-1:0]   left_elem;

	assign rdy_s2    = !v_s2 || dn_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign up_ready  = rdy_s1;
	assign dn_valid  = v_s2;
	assign dn_item   = item_s2;
	assign left_elem = $signed(up_item.elem[cell_idx]);
	assign wr_en     = up_valid && rdy_s1 && (up_item.cmd == CMD_LOAD)
		&& (up_item.row == cell_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (wr_en) begin
				coef_q <= up_item.elem;
			end
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s1) begin
			item_s1 <= up_item;
			for (int j = 0; j < DIM; j++) begin
				prod_s1[j] <= PROD_W'(left_elem) * PROD_W'($signed(coef_q[j]));
			end
		end
		if (v_s1 && rdy_s2) begin
			item_s2.cmd  <= item_s1.cmd;
			item_s2.row  <= item_s1.row;
			item_s2.elem <= item_s1.elem;
			for (int j = 0; j < DIM; j++) begin
				item_s2.acc[j] <= $signed(item_s1.acc[j]) + ACC_W'(prod_s1[j]);
			end
		end
	end

	`M4RT_ASSERT_NEXT(a_load_writes_row, wr_en, coef_q == $past(up_item.elem))
	`M4RT_ASSERT_NEXT(a_row_holds, !wr_en, $stable(coef_q))
endmodule

FILE: hw/rtl/m4rt_sat.sv
// Output stage: floor shift of the column sums, saturation to 32 bits and the
// result register. Drops load requests. Depends on m4rt_pkg, m4rt_if, macros.
`timescale 1ns / 1ps
`include "matrix_4x4_row_transform_core_macros.svh"
module m4rt_sat
	import m4rt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  m4rt_item_t        up_item,
	output logic              up_ready,
	m4rt_res_if.source        res
);
	logic [WORD_W-1:0] col [DIM];
	logic              clip;
	logic              take_load;
	logic              take_mul;

	assign up_ready  = !res.valid || res.ready;
	assign take_load = up_valid && up_ready && (up_item.cmd == CMD_LOAD);
	assign take_mul  = up_valid && up_ready && (up_item.cmd == CMD_MUL);

	always_comb begin
		logic [SHIFT_W-1:0]          sh;
		logic [SHIFT_W-WORD_W:0]     hi;
		clip = 1'b0;
		for (int j = 0; j < DIM; j++) begin
			sh = up_item.acc[j][ACC_W-1:FRAC_W];
			hi = sh[SHIFT_W-1:WORD_W-1];
			if ((&hi) || !(|hi)) begin
				col[j] = sh[WORD_W-1:0];
			end else begin
				clip   = 1'b1;
				col[j] = sh[SHIFT_W-1] ? WORD_MIN : WORD_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (up_ready) begin
			res.valid <= up_valid && (up_item.cmd == CMD_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			res.out_row   <= up_item.row;
			res.out_col0  <= $signed(col[0]);
			res.out_col1  <= $signed(col[1]);
			res.out_col2  <= $signed(col[2]);
			res.out_col3  <= $signed(col[3]);
			res.saturated <= clip;
		end
	end

	`M4RT_ASSERT_NEXT(a_load_no_result, take_load, !res.valid)
	`M4RT_ASSERT_NEXT(a_mul_gives_row, take_mul, res.valid && res.out_row == $past(up_item.row))
endmodule

FILE: hw/rtl/matrix_4x4_row_transform_core.sv
// 4x4 Q16.16 matrix row transform: a chain of four cells, one per stored row.
// A multiply request passes two registers per cell and then the saturating output register
// (the first loaded at the accepting edge). Throughput: one request per cycle while the
// result channel is ready; a stall there holds the chain back. Loads give no result.
// Reset (arst_n, asynchronous) zeroes the stored matrix and empties the chain.
`timescale 1ns / 1ps
module matrix_4x4_row_transform_core
	import m4rt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	m4rt_req_if.sink   req,
	m4rt_res_if.source res
);
	logic       ch_valid [DIM+1];
	logic       ch_ready [DIM+1];
	m4rt_item_t ch_item  [DIM+1];

	assign ch_valid[0] = req.valid;
	assign req.ready   = ch_ready[0];
	assign ch_item[0]  = '{cmd: m4rt_cmd_t'(req.command), row: req.row_index,
		elem: {req.elem3, req.elem2, req.elem1, req.elem0}, acc: '0};

	for (genvar k = 0; k < DIM; k++) begin : g_cell
		m4rt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (ROW_W'(k)),
			.up_valid (ch_valid[k]),
			.up_item  (ch_item[k]),
			.up_ready (ch_ready[k]),
			.dn_valid (ch_valid[k+1]),
			.dn_item  (ch_item[k+1]),
			.dn_ready (ch_ready[k+1])
		);
	end

	m4rt_sat u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ch_valid[DIM]),
		.up_item  (ch_item[DIM]),
		.up_ready (ch_ready[DIM]),
		.res      (res)
	);
endmodule

FILE: test/tb.sv
// Self-checking testbench for matrix_4x4_row_transform_core: drives load and multiply
// requests and checks every product row against a Q16.16 row-product scoreboard.
// Depends on m4rt_pkg, m4rt_req_if / m4rt_res_if and the core itself.
`timescale 1ns / 1ps
module tb;
	import m4rt_pkg::*;

	localparam int PERIOD       = 12;
	localparam int RESET_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 340;
	localparam int REPORT_MAX   = 10;

	localparam logic [WORD_W-1:0] ONE = 32'h0001_0000;
	localparam logic [WORD_W-1:0] ZERO = '0;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic signed [ACC_W-1:0] COL_HI = {{(ACC_W-WORD_W){1'b0}}, WORD_MAX};
	localparam logic signed [ACC_W-1:0] COL_LO = {{(ACC_W-WORD_W){1'b1}}, WORD_MIN};

	typedef struct packed {
		m4rt_cmd_t                  cmd;
		logic [ROW_W-1:0]           row;
		logic [DIM-1:0][WORD_W-1:0] elem;
	} request_t;

	typedef struct packed {
		logic [ROW_W-1:0]           row;
		logic [DIM-1:0][WORD_W-1:0] col;
		logic                       sat;
	} row_result_t;

	class row_product_check;
		logic signed [WORD_W-1:0] stored [DIM][DIM];
		row_result_t expected_rows [$];
		int loads;
		int multiplies;
		int rows_checked;
		int clipped_rows;
		int errors;

		function new();
			foreach (stored[i, j])
				stored[i][j] = '0;
			loads = 0;
			multiplies = 0;
			rows_checked = 0;
			clipped_rows = 0;
			errors = 0;
		endfunction

		function row_result_t predict_product_row(request_t r);
			row_result_t p;
			logic signed [ACC_W-1:0] acc;
			logic signed [ACC_W-1:0] floor_sum;
			longint prod;
			p.row = r.row;
			p.sat = 1'b0;
			p.col = '0;
			for (int j = 0; j < DIM; j++) begin
				acc = '0;
				for (int k = 0; k < DIM; k++) begin
					prod = longint'(signed'(r.elem[k])) * longint'(stored[k][j]);
					acc = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
				end
				floor_sum = acc >>> FRAC_W;
				if (floor_sum > COL_HI) begin
					p.col[j] = WORD_MAX;
					p.sat = 1'b1;
				end else if (floor_sum < COL_LO) begin
					p.col[j] = WORD_MIN;
					p.sat = 1'b1;
				end else begin
					p.col[j] = floor_sum[WORD_W-1:0];
				end
			end
			return p;
		endfunction

		function void note_request(request_t r);
			if (r.cmd == CMD_LOAD) begin
				for (int j = 0; j < DIM; j++)
					stored[r.row][j] = r.elem[j];
				loads++;
			end else begin
				expected_rows.push_back(predict_product_row(r));
				multiplies++;
			end
		endfunction

		function void check_result(row_result_t got);
			row_result_t want;
			if (expected_rows.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: unexpected result, row %0d", $time, got.row);
				return;
			end
			want = expected_rows.pop_front();
			rows_checked++;
			if (want.sat)
				clipped_rows++;
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t: mismatch, expected row %0d cols %h %h %h %h sat %b", $time,
						want.row, want.col[0], want.col[1], want.col[2], want.col[3], want.sat);
					$display("%0t:           actual   row %0d cols %h %h %h %h sat %b", $time,
						got.row, got.col[0], got.col[1], got.col[2], got.col[3], got.sat);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int idle_pct;
	int stall_pct;
	int hold_asked;
	int quiet;
	row_product_check board;

	m4rt_req_if req_ch ();
	m4rt_res_if res_ch ();

	matrix_4x4_row_transform_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always #(PERIOD / 2) clk = ~clk;

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_result('{res_ch.out_row,
				{res_ch.out_col3, res_ch.out_col2, res_ch.out_col1, res_ch.out_col0},
				res_ch.saturated});
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic request_t mk_req(m4rt_cmd_t c, logic [ROW_W-1:0] row,
		logic [WORD_W-1:0] e0, logic [WORD_W-1:0] e1, logic [WORD_W-1:0] e2,
		logic [WORD_W-1:0] e3);
		request_t r;
		r.cmd = c;
		r.row = row;
		r.elem = {e3, e2, e1, e0};
		return r;
	endfunction

	// mix of extremes, full-range words and small magnitudes that stay unclipped
	function automatic logic [WORD_W-1:0] rand_word();
		logic [WORD_W-1:0] w;
		int unsigned mag;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(5))
					0: w = WORD_MAX;
					1: w = WORD_MIN;
					2: w = ZERO;
					3: w = ALL_ONES;
					4: w = ONE;
					default: w = -ONE;
				endcase
			end
			1, 2, 3: w = $urandom;
			default: begin
				mag = $urandom_range(1 << 20);
				w = $urandom_range(1) ? -mag : mag;
			end
		endcase
		return w;
	endfunction

	function automatic request_t rand_req(m4rt_cmd_t c, logic [ROW_W-1:0] row);
		return mk_req(c, row, rand_word(), rand_word(), rand_word(), rand_word());
	endfunction

	task automatic send_request(request_t r);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.command <= r.cmd;
		req_ch.row_index <= r.row;
		req_ch.elem0 <= r.elem[0];
		req_ch.elem1 <= r.elem[1];
		req_ch.elem2 <= r.elem[2];
		req_ch.elem3 <= r.elem[3];
		do
			@(posedge clk);
		while (!req_ch.ready);
		board.note_request(r);
	endtask

	task automatic run_phase(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < DIM; i++)
			send_request(rand_req(CMD_LOAD, ROW_W'(i)));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 20)
				send_request(rand_req(CMD_LOAD, ROW_W'($urandom_range(DIM - 1))));
			else
				send_request(rand_req(CMD_MUL, ROW_W'($urandom_range(DIM - 1))));
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_asked = 0;
		quiet = 0;
		req_ch.valid = 1'b0;
		req_ch.command = 1'b0;
		req_ch.row_index = '0;
		req_ch.elem0 = '0;
		req_ch.elem1 = '0;
		req_ch.elem2 = '0;
		req_ch.elem3 = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// multiply against the zeroed matrix
		send_request(mk_req(CMD_MUL, ROW_W'(0), WORD_MAX, WORD_MIN, ALL_ONES, ONE));
		send_request(rand_req(CMD_MUL, ROW_W'(3)));
		// identity: rows come back unchanged, including the floor of -1
		for (int i = 0; i < DIM; i++)
			send_request(mk_req(CMD_LOAD, ROW_W'(i), i == 0 ? ONE : ZERO,
				i == 1 ? ONE : ZERO, i == 2 ? ONE : ZERO, i == 3 ? ONE : ZERO));
		send_request(mk_req(CMD_MUL, ROW_W'(1), WORD_MAX, WORD_MIN, ZERO, ALL_ONES));
		// clip both ways
		for (int i = 0; i < DIM; i++)
			send_request(mk_req(CMD_LOAD, ROW_W'(i), WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
		send_request(mk_req(CMD_MUL, ROW_W'(0), WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
		send_request(mk_req(CMD_MUL, ROW_W'(1), WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
		send_request(mk_req(CMD_MUL, ROW_W'(2), WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
		send_request(mk_req(CMD_LOAD, ROW_W'(2), WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
		send_request(mk_req(CMD_MUL, ROW_W'(3), ZERO, ZERO, WORD_MIN, ZERO));
		send_request(mk_req(CMD_MUL, ROW_W'(0), ONE, ZERO, ONE, ZERO));

		run_phase(PHASE_ITEMS, 0, 0);
		run_phase(PHASE_ITEMS, 54, 0);
		run_phase(PHASE_ITEMS, 0, 54);
		run_phase(PHASE_ITEMS, 11, 11);

		// long receiver hold-off while requests keep coming
		idle_pct = 0;
		stall_pct = 0;
		hold_asked++;
		for (int n = 0; n < 60; n++)
			send_request(rand_req($urandom_range(3) == 0 ? CMD_LOAD : CMD_MUL,
				ROW_W'($urandom_range(DIM - 1))));

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d row loads and %0d multiplies; %0d product rows checked, %0d clipped.",
			board.loads, board.multiplies, board.rows_checked, board.clipped_rows);
		$display("Idling phases: none, sender, receiver, both, plus a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", board.errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
